### sv/sli_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int ENTRY_W  = 32;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 5;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} sli_op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_DELETED   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} sli_status_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		logic                      valid;
		logic                      le;
		logic signed [ENTRY_W-1:0] entry;
	} sli_link_t;

	// Broadcast command to every cell for the current beat.
	typedef struct packed {
		logic ins;
		logic del;
	} sli_cmd_t;

endpackage

### sv/sorted_list_insert_delete.sv
// Top level of the sorted list block: cell row, count and result register.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells. Each cell compares the broadcast key with its own entry and, on an
// insert or delete, takes the key or a neighbor's entry in the same cycle.
//
// Input channel s_*: one beat per operation. s_tuser selects insert (0) or
// delete (1); s_tdata carries the signed value. An insert goes after every
// equal entry; a delete removes the first equal entry.
// Output channel m_*: one beat per operation, m_tdata = {1'b0, entry_count, status}.
// Status: inserted, insert dropped because the list is full, deleted, not found.
//
// The result is registered and appears in the cycle after the input beat is taken.
// Throughput: one operation per cycle while the receiver keeps up, set by the
// single compare-and-shift step that every cell does at once across the row.
// When the receiver stalls, the result is held in the output register and
// s_tready drops until it is taken; no beat is lost.
// Reset empties the list (count zero, every cell invalid) and clears m_tvalid.
module sorted_list_insert_delete (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);

	localparam int N = sli_pkg::CAPACITY;

	logic                               accept;
	logic                               is_insert;
	logic                               full;
	logic                               found;
	logic signed [sli_pkg::ENTRY_W-1:0] key;
	sli_pkg::sli_cmd_t                  cmd;
	sli_pkg::sli_link_t                 links [N];
	sli_pkg::sli_link_t                 left_edge;
	sli_pkg::sli_link_t                 right_edge;
	logic [N-1:0]                       eq_vec;

	logic [sli_pkg::COUNT_W-1:0]        count_q;
	logic [sli_pkg::COUNT_W-1:0]        count_next;
	sli_pkg::sli_status_t               status_next;
	logic                               out_valid_q;
	sli_pkg::sli_status_t               out_status_q;
	logic [sli_pkg::OUT_CNT_W-1:0]      out_count_q;

	// Take a new beat whenever the result register is free or being drained.
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign key       = s_tdata;
	assign is_insert = (s_tuser == sli_pkg::OP_INSERT);
	assign full      = (count_q == sli_pkg::COUNT_W'(N));
	assign found     = |eq_vec;

	assign cmd.ins = accept && is_insert && !full;
	assign cmd.del = accept && !is_insert && found;

	// Left of the first cell everything counts as "not above key", so cell 0
	// takes the key when its own entry is above it.
	assign left_edge.valid  = 1'b0;
	assign left_edge.le     = 1'b1;
	assign left_edge.entry  = '0;
	assign right_edge.valid = 1'b0;
	assign right_edge.le    = 1'b0;
	assign right_edge.entry = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		sli_pkg::sli_link_t left_in;
		sli_pkg::sli_link_t right_in;

		if (i == 0) begin : g_first
			assign left_in = left_edge;
		end else begin : g_mid_l
			assign left_in = links[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_in = right_edge;
		end else begin : g_mid_r
			assign right_in = links[i+1];
		end

		sli_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.key    (key),
			.left   (left_in),
			.right  (right_in),
			.link   (links[i]),
			.eq     (eq_vec[i])
		);
	end

	// Status and new count for this beat.
	always_comb begin
		count_next  = count_q;
		status_next = sli_pkg::ST_INSERTED;
		if (is_insert) begin
			if (full) begin
				status_next = sli_pkg::ST_FULL;
			end else begin
				status_next = sli_pkg::ST_INSERTED;
				count_next  = count_q + sli_pkg::COUNT_W'(1);
			end
		end else begin
			if (found) begin
				status_next = sli_pkg::ST_DELETED;
				count_next  = count_q - sli_pkg::COUNT_W'(1);
			end else begin
				status_next = sli_pkg::ST_NOT_FOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			// Hold the result until taken; refill in the same cycle it drains.
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_next;
			out_count_q  <= sli_pkg::OUT_CNT_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_count_q, out_status_q};

endmodule

### sv/sli_cell.sv
// One storage cell of the sorted row: compare against the key and shift locally.
module sli_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sli_pkg::sli_cmd_t                 cmd,
	input  logic signed [sli_pkg::ENTRY_W-1:0] key,
	input  sli_pkg::sli_link_t                left,
	input  sli_pkg::sli_link_t                right,
	output sli_pkg::sli_link_t                link,
	output logic                              eq
);

	logic                              valid_q;
	logic signed [sli_pkg::ENTRY_W-1:0] entry_q;
	logic                              le;
	logic                              ge;

	assign le = valid_q && (entry_q <= key);
	assign ge = valid_q && (entry_q >= key);
	assign eq = valid_q && (entry_q == key);

	assign link.valid = valid_q;
	assign link.le    = le;
	assign link.entry = entry_q;

	// Insert: keep if not above key, take key at the boundary, else take left neighbor.
	// Delete: every cell from the matching one on takes its right neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !le) begin
			valid_q <= left.le ? 1'b1 : left.valid;
		end else if (cmd.del && ge) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !le) begin
			entry_q <= left.le ? key : left.entry;
		end else if (cmd.del && ge) begin
			entry_q <= right.entry;
		end
	end

endmodule

### sv/sli_checker.sv
// Port-level assertions for the sorted list block, bound to the top level.
module sli_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// A stalled result holds its beat.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every taken input produces a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted beat");

	// An insert only reports inserted or full.
	a_ins_status: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == sli_pkg::OP_INSERT) |=> m_tdata[1] == 1'b0)
		else $error("insert reported a delete status");

	// A successful insert leaves at least one entry.
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == sli_pkg::ST_INSERTED) |-> m_tdata[6:2] != 5'd0)
		else $error("inserted with empty list");

	// A dropped insert means the list is at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == sli_pkg::ST_FULL)
		|-> m_tdata[6:2] == sli_pkg::OUT_CNT_W'(sli_pkg::CAPACITY))
		else $error("full status below capacity");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/sorted_list_insert_delete_tb.sv
// Self-checking testbench for the sorted list insert/delete block.
module sorted_list_insert_delete_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 7;
	localparam int PHASE_OPS    = 350;  // four pacing phases, about 1400 ops in all
	localparam int HOLD_CYCLES  = 60;   // long output hold-off, counted by the monitor
	localparam int DRAIN_CYCLES = 10;   // settle time after the last reply
	localparam int STALL_LIMIT  = 1000; // cycles with no beat on either side
	localparam int POOL_N       = 12;

	// Pacing of the two channels for the current phase.
	typedef enum int {
		PACE_FULL,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct {
		sli_pkg::sli_op_t   op;
		logic signed [31:0] value;
	} list_op_t;

	typedef struct {
		sli_pkg::sli_status_t            status;
		logic [sli_pkg::OUT_CNT_W-1:0]   count;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [0:0]  s_tuser = '0;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [1:0] status, [6:2] entry_count, [7] zero

	list_op_t           op_q[$];      // ops waiting to be offered on the input
	reply_t             reply_q[$];   // replies owed by the block, oldest first
	logic signed [31:0] sorted_q[$];  // shadow copy of the stored list
	logic signed [31:0] key_pool [POOL_N];

	pace_t  pace = PACE_FULL;
	bit     hold_req = 1'b0;
	int     hold_cnt = 0;
	int     fail_count = 0;
	int     quiet_cycles = 0;
	list_op_t next_op;
	reply_t   drv_reply;
	reply_t   want;

	sorted_list_insert_delete DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	// Apply one op to the shadow list and work out the reply the block owes.
	// Inserts go after every entry <= value, so equal values stay in arrival
	// order; deletes take the lowest-position equal entry.
	task automatic list_apply(input sli_pkg::sli_op_t op, input logic signed [31:0] value,
			output reply_t r);
		int pos;
		pos = 0;
		if (op == sli_pkg::OP_INSERT) begin
			if (sorted_q.size() >= sli_pkg::CAPACITY) begin
				r.status = sli_pkg::ST_FULL;
			end else begin
				while (pos < sorted_q.size() && sorted_q[pos] <= value)
					pos++;
				sorted_q.insert(pos, value);
				r.status = sli_pkg::ST_INSERTED;
			end
		end else begin
			while (pos < sorted_q.size() && sorted_q[pos] != value)
				pos++;
			if (pos >= sorted_q.size()) begin
				r.status = sli_pkg::ST_NOT_FOUND;
			end else begin
				sorted_q.delete(pos);
				r.status = sli_pkg::ST_DELETED;
			end
		end
		r.count = sli_pkg::OUT_CNT_W'(sorted_q.size());
	endtask

	task automatic push_op(input sli_pkg::sli_op_t op, input logic signed [31:0] value);
		list_op_t it;
		it.op = op;
		it.value = value;
		op_q.push_back(it);
	endtask

	// Mostly reuse a small pool so deletes find matches and duplicates pile up.
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 99) < 70)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom;
	endfunction

	function automatic bit sender_gap();
		case (pace)
			PACE_SEND_IDLE: return $urandom_range(0, 99) < 75;
			PACE_BOTH:      return $urandom_range(0, 99) < 26;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (pace)
			PACE_RECV_STALL: return $urandom_range(0, 99) < 75;
			PACE_BOTH:       return $urandom_range(0, 99) < 26;
			default:         return 1'b0;
		endcase
	endfunction

	// Input driver: predict on every accepted beat, then offer the next op
	// once the current one is gone (or nothing was offered).
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				list_apply(sli_pkg::sli_op_t'(s_tuser), s_tdata, drv_reply);
				reply_q.push_back(drv_reply);
			end
			if (!s_tvalid || s_tready) begin
				if (op_q.size() > 0 && !sender_gap()) begin
					next_op = op_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_op.value;
					s_tuser  <= next_op.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each reply beat against the oldest owed reply,
	// then pace m_tready. A hold request drops m_tready for HOLD_CYCLES.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					report($sformatf("reply beat 0x%02h with nothing owed", m_tdata));
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[1:0] != want.status)
						report($sformatf("status %0d, want %s",
							m_tdata[1:0], want.status.name()));
					if (m_tdata[6:2] != want.count)
						report($sformatf("entry_count %0d, want %0d",
							m_tdata[6:2], want.count));
					if (m_tdata[7] !== 1'b0)
						report("pad bit 7 of m_tdata not zero");
				end
			end
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES) begin
					hold_req = 1'b0;
					hold_cnt = 0;
				end
			end else begin
				m_tready <= !receiver_stall();
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("sorted_list_insert_delete_tb NOT OK");
				$finish;
			end
		end
	end

	// Wait at negedges until every op is offered, taken and answered.
	task automatic drain();
		while (op_q.size() != 0 || s_tvalid || reply_q.size() != 0 || hold_req)
			@(negedge clk);
	endtask

	initial begin
		int n;
		int burst_len;
		int ins_pct;
		sli_pkg::sli_op_t op;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: delete from empty, extremes, equal values, first-equal
		// delete, miss, then fill to capacity and overflow.
		push_op(sli_pkg::OP_DELETE, 32'sd0);
		push_op(sli_pkg::OP_INSERT, 32'sd0);
		push_op(sli_pkg::OP_INSERT, 32'sh8000_0000);
		push_op(sli_pkg::OP_INSERT, 32'sh7fff_ffff);
		push_op(sli_pkg::OP_INSERT, -32'sd1);
		push_op(sli_pkg::OP_INSERT, 32'sd0);
		push_op(sli_pkg::OP_INSERT, 32'sd1);
		push_op(sli_pkg::OP_DELETE, 32'sd0);
		push_op(sli_pkg::OP_DELETE, 32'sd5);
		push_op(sli_pkg::OP_DELETE, 32'sh8000_0000);
		push_op(sli_pkg::OP_DELETE, 32'sh7fff_ffff);
		push_op(sli_pkg::OP_INSERT, 32'sh8000_0000);
		push_op(sli_pkg::OP_INSERT, 32'sh7fff_ffff);
		push_op(sli_pkg::OP_INSERT, 32'shaaaa_aaaa);
		push_op(sli_pkg::OP_INSERT, 32'sh5555_5555);
		push_op(sli_pkg::OP_INSERT, 32'sd1);
		push_op(sli_pkg::OP_INSERT, 32'sd1);
		push_op(sli_pkg::OP_INSERT, -32'sd1);
		push_op(sli_pkg::OP_INSERT, 32'sh0000_ffff);
		push_op(sli_pkg::OP_INSERT, 32'shffff_0000);
		push_op(sli_pkg::OP_INSERT, 32'sd100);
		push_op(sli_pkg::OP_INSERT, -32'sd100);
		push_op(sli_pkg::OP_INSERT, 32'sh7fff_ffff);
		push_op(sli_pkg::OP_INSERT, 32'sh8000_0000);
		push_op(sli_pkg::OP_INSERT, 32'sd0);  // list full here: dropped
		drain();

		// Random phases, one per pacing mode.
		for (int p = 0; p < 4; p++) begin
			pace = pace_t'(p);
			key_pool[0] = 32'sh8000_0000;
			key_pool[1] = 32'sh7fff_ffff;
			key_pool[2] = 32'sd0;
			key_pool[3] = -32'sd1;
			for (int k = 4; k < POOL_N; k++)
				key_pool[k] = (k < 8) ? $signed(32'($urandom_range(0, 8)) - 4) : $urandom;
			n = 0;
			// Bursts lean toward inserts or deletes so the count sweeps the
			// whole range from empty to full.
			while (n < PHASE_OPS) begin
				burst_len = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0:       ins_pct = 85;
					1:       ins_pct = 15;
					default: ins_pct = 50;
				endcase
				for (int k = 0; k < burst_len && n < PHASE_OPS; k++) begin
					op = ($urandom_range(0, 99) < ins_pct) ?
						sli_pkg::OP_INSERT : sli_pkg::OP_DELETE;
					push_op(op, pick_value());
					n++;
				end
			end
			// Hold off the output while the sender keeps offering, so the
			// block backs up and drops s_tready.
			if (p == 0) begin
				@(negedge clk);
				hold_req = 1'b1;
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_list_insert_delete_tb OK");
		else
			$display("sorted_list_insert_delete_tb NOT OK");
		$finish;
	end

endmodule
